// File: rtl/pfgb_pkg.sv
`timescale 1ns / 1ps

package pfgb_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int GLYPH_WIDTH   = 12;
    localparam int GLYPH_HEIGHT  = 24;

    // screen sizes are powers of two, so wrap is plain truncation
    localparam int X_W       = $clog2(SCREEN_WIDTH);
    localparam int Y_W       = $clog2(SCREEN_HEIGHT);
    localparam int PAGE_W    = Y_W - 3;
    localparam int ADDR_W    = PAGE_W + X_W;
    localparam int FB_PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int FB_BYTES  = FB_PAGES * SCREEN_WIDTH;

    localparam int GIDX_W      = 6;
    localparam int GLYPH_PAGES = (GLYPH_HEIGHT + 7) / 8;
    localparam int GLYPH_BYTES = GLYPH_PAGES * GLYPH_WIDTH;
    localparam int GPAGE_W     = (GLYPH_PAGES > 1) ? $clog2(GLYPH_PAGES) : 1;
    localparam int GLYPH_TAIL  = GLYPH_HEIGHT - (GLYPH_PAGES - 1) * 8;
    localparam logic [7:0] GLYPH_TAIL_MASK = 8'((16'd1 << GLYPH_TAIL) - 16'd1);

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_POINT = 2'd1,
        OP_GLYPH = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_WR_A,
        ST_RD_B,
        ST_WR_B
    } state_t;

    // one decoded command: up to two byte updates
    typedef struct packed {
        logic              is_read;
        logic              two;
        logic [ADDR_W-1:0] addr_a;
        logic [7:0]        data_a;
        logic [7:0]        mask_a;
        logic [ADDR_W-1:0] addr_b;
        logic [7:0]        data_b;
        logic [7:0]        mask_b;
    } plan_t;

    // sequencer to store / merge unit
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_bits;
        logic [7:0]        wr_mask;
        logic              strobe;
    } ctl_t;

endpackage

// File: rtl/pfgb_store.sv
`timescale 1ns / 1ps

module pfgb_store
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        rd_en,
    input  logic [pfgb_pkg::ADDR_W-1:0] rd_addr,
    input  logic                        wr_en,
    input  logic [pfgb_pkg::ADDR_W-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    output logic [7:0]                  rd_data
);

    logic [7:0]                    mem [pfgb_pkg::FB_BYTES];
    logic [pfgb_pkg::FB_BYTES-1:0] valid_reg;
    logic [7:0]                    mem_q_reg;
    logic                          vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // a byte never written since reset or clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_q_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : 8'h00;

endmodule

// File: rtl/pfgb_seq.sv
`timescale 1ns / 1ps

module pfgb_seq
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [1:0]                  operation,
    input  logic [pfgb_pkg::X_W-1:0]    x_pos,
    input  logic [pfgb_pkg::Y_W-1:0]    y_pos,
    input  logic                        pixel_on,
    input  logic [7:0]                  pattern_byte,
    input  logic [pfgb_pkg::GIDX_W-1:0] glyph_byte_index,
    input  logic [pfgb_pkg::ADDR_W-1:0] read_index,
    output logic                        busy,
    output logic                        clear,
    output pfgb_pkg::ctl_t              ctl
);

    pfgb_pkg::state_t state_reg;
    pfgb_pkg::state_t state_next;
    pfgb_pkg::plan_t  plan_reg;
    pfgb_pkg::plan_t  plan_next;
    pfgb_pkg::op_t    op;

    logic                         accept;
    logic                         glyph_ok;
    logic [pfgb_pkg::GPAGE_W-1:0] gpage;
    logic [pfgb_pkg::GIDX_W-1:0]  gcol;
    logic [pfgb_pkg::X_W-1:0]     gx;
    logic [pfgb_pkg::Y_W-1:0]     gy;
    logic [pfgb_pkg::PAGE_W-1:0]  gpage_b;
    logic [7:0]                   grow_mask;
    logic [15:0]                  wide_data;
    logic [15:0]                  wide_mask;

    assign op       = pfgb_pkg::op_t'(operation);
    assign busy     = (state_reg != pfgb_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign clear    = accept && (op == pfgb_pkg::OP_CLEAR);
    assign glyph_ok = (glyph_byte_index < pfgb_pkg::GIDX_W'(pfgb_pkg::GLYPH_BYTES));

    // glyph page by compare chain, column by subtraction
    always_comb
    begin
        gpage = '0;
        for (int p = 1; p < pfgb_pkg::GLYPH_PAGES; p++)
        begin
            if (glyph_byte_index >= pfgb_pkg::GIDX_W'(p * pfgb_pkg::GLYPH_WIDTH))
            begin
                gpage = pfgb_pkg::GPAGE_W'(p);
            end
        end
    end

    assign gcol = pfgb_pkg::GIDX_W'(glyph_byte_index
                  - pfgb_pkg::GIDX_W'(gpage) * pfgb_pkg::GIDX_W'(pfgb_pkg::GLYPH_WIDTH));
    assign gx   = pfgb_pkg::X_W'(x_pos + pfgb_pkg::X_W'(gcol));
    assign gy   = pfgb_pkg::Y_W'(y_pos + (pfgb_pkg::Y_W'(gpage) << 3));
    assign gpage_b = pfgb_pkg::PAGE_W'(gy[pfgb_pkg::Y_W-1:3] + 1'b1);
    assign grow_mask = (gpage == pfgb_pkg::GPAGE_W'(pfgb_pkg::GLYPH_PAGES - 1))
                       ? pfgb_pkg::GLYPH_TAIL_MASK : 8'hFF;
    // bits below the byte boundary spill into the next page
    assign wide_data = {8'h00, pattern_byte} << gy[2:0];
    assign wide_mask = {8'h00, grow_mask} << gy[2:0];

    always_comb
    begin
        plan_next         = plan_reg;
        plan_next.is_read = 1'b0;
        plan_next.two     = 1'b0;
        plan_next.addr_b  = {gpage_b, gx};
        plan_next.data_b  = wide_data[15:8];
        plan_next.mask_b  = wide_mask[15:8];
        unique case (op)
            pfgb_pkg::OP_POINT:
            begin
                plan_next.addr_a = {y_pos[pfgb_pkg::Y_W-1:3], x_pos};
                plan_next.data_a = {8{pixel_on}};
                plan_next.mask_a = 8'h01 << y_pos[2:0];
            end
            pfgb_pkg::OP_GLYPH:
            begin
                plan_next.addr_a = {gy[pfgb_pkg::Y_W-1:3], gx};
                plan_next.data_a = wide_data[7:0];
                plan_next.mask_a = wide_mask[7:0];
                plan_next.two    = |wide_mask[15:8];
            end
            pfgb_pkg::OP_READ:
            begin
                plan_next.addr_a  = read_index;
                plan_next.is_read = 1'b1;
            end
            pfgb_pkg::OP_CLEAR:
            begin
                plan_next.addr_a = read_index;
            end
            default:
            begin
                plan_next.addr_a = read_index;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plan_reg <= plan_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfgb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfgb_pkg::ST_IDLE:
            begin
                if (accept && (op != pfgb_pkg::OP_CLEAR)
                    && ((op != pfgb_pkg::OP_GLYPH) || glyph_ok))
                begin
                    state_next = pfgb_pkg::ST_RD_A;
                end
            end
            pfgb_pkg::ST_RD_A:
            begin
                state_next = pfgb_pkg::ST_WR_A;
            end
            pfgb_pkg::ST_WR_A:
            begin
                state_next = plan_reg.two ? pfgb_pkg::ST_RD_B : pfgb_pkg::ST_IDLE;
            end
            pfgb_pkg::ST_RD_B:
            begin
                state_next = pfgb_pkg::ST_WR_B;
            end
            pfgb_pkg::ST_WR_B:
            begin
                state_next = pfgb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pfgb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.rd_addr = plan_reg.addr_a;
        ctl.wr_addr = plan_reg.addr_a;
        ctl.wr_bits = plan_reg.data_a;
        ctl.wr_mask = plan_reg.mask_a;
        unique case (state_reg)
            pfgb_pkg::ST_IDLE:
            begin
                ctl.rd_en = 1'b0;
            end
            pfgb_pkg::ST_RD_A:
            begin
                ctl.rd_en = 1'b1;
            end
            pfgb_pkg::ST_WR_A:
            begin
                ctl.wr_en  = !plan_reg.is_read;
                ctl.strobe = plan_reg.is_read;
            end
            pfgb_pkg::ST_RD_B:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = plan_reg.addr_b;
            end
            pfgb_pkg::ST_WR_B:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_addr = plan_reg.addr_b;
                ctl.wr_bits = plan_reg.data_b;
                ctl.wr_mask = plan_reg.mask_b;
            end
            default:
            begin
                ctl.rd_en = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/page_framebuffer_glyph_blitter_top.sv
`timescale 1ns / 1ps

// 64x32 monochrome framebuffer, page ordered: byte (y/8)*64 + x, bit y%8.
// Command channel: a word is taken on a rising edge with start high and busy
// low. operation selects clear, point, glyph byte or read; the other fields
// are used by the operations that need them.
// Result channel: a read returns read_data, shown for exactly one cycle with
// read_valid high. The receiver cannot hold it off; it must take it then.
// Operation flow from the accepting edge until busy drops:
//   clear: the whole store is wiped at the accepting edge; busy stays low.
//   point, read: memory read state, then write-back or result state.
//   glyph byte: one read and write-back if it stays inside one page byte, two
//   if it spans two; a glyph index past the glyph changes nothing.
// read_valid is raised in ST_WR_A, after the memory read in ST_RD_A. Each byte
// update is a read then a write-back, through separate store read and write ports.
// Reset clears the sequencer state and marks every byte as zero; no sweep runs.
module page_framebuffer_glyph_blitter_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] operation,
    input  logic [5:0] x_pos,
    input  logic [4:0] y_pos,
    input  logic       pixel_on,
    input  logic [7:0] pattern_byte,
    input  logic [5:0] glyph_byte_index,
    input  logic [7:0] read_index,
    output logic       read_valid,
    output logic [7:0] read_data
);

    pfgb_pkg::ctl_t ctl;
    logic           clear;
    logic [7:0]     rd_data;
    logic [7:0]     merged;

    pfgb_seq u_seq
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .operation        (operation),
        .x_pos            (x_pos),
        .y_pos            (y_pos),
        .pixel_on         (pixel_on),
        .pattern_byte     (pattern_byte),
        .glyph_byte_index (glyph_byte_index),
        .read_index       (read_index),
        .busy             (busy),
        .clear            (clear),
        .ctl              (ctl)
    );

    // shared read-modify-write merge
    assign merged = (rd_data & ~ctl.wr_mask) | (ctl.wr_bits & ctl.wr_mask);

    pfgb_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (clear),
        .rd_en   (ctl.rd_en),
        .rd_addr (ctl.rd_addr),
        .wr_en   (ctl.wr_en),
        .wr_addr (ctl.wr_addr),
        .wr_data (merged),
        .rd_data (rd_data)
    );

    assign read_valid = ctl.strobe;
    assign read_data  = rd_data;

endmodule

// File: rtl/pfgb_checker.sv
`timescale 1ns / 1ps

module pfgb_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] operation,
    input  logic       read_valid,
    input  logic [7:0] read_data
);

    logic take;

    assign take = start && !busy;

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (operation == pfgb_pkg::OP_READ)) |-> ##2 read_valid)
        else $error("read word not returned two cycles after accept");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (operation != pfgb_pkg::OP_READ)) |-> ##2 !read_valid)
        else $error("result strobe without a read");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        read_valid |-> busy)
        else $error("result strobe while idle");

    a_clear_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (take && (operation == pfgb_pkg::OP_CLEAR)) |=> !busy)
        else $error("clear kept the block busy");

    a_clear_read: assert property (@(posedge clk) disable iff (!rst_n)
        ((take && (operation == pfgb_pkg::OP_CLEAR))
         ##1 (take && (operation == pfgb_pkg::OP_READ))) |-> ##2 (read_data == 8'h00))
        else $error("read right after clear returned nonzero");

endmodule

bind page_framebuffer_glyph_blitter_top pfgb_checker u_pfgb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .read_valid (read_valid),
    .read_data  (read_data)
);

// File: tb/page_framebuffer_glyph_blitter_top_test.sv
`timescale 1ns / 1ps

module page_framebuffer_glyph_blitter_top_test;

    import pfgb_pkg::*;

    typedef struct packed {
        op_t        op;
        logic [5:0] x;
        logic [4:0] y;
        logic       on;
        logic [7:0] bits;
        logic [5:0] gidx;
        logic [7:0] raddr;
    } word_t;

    localparam int N_WORDS = 1600;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    word_t      cmd = '0;
    logic       busy;
    logic       read_valid;
    logic [7:0] read_data;

    word_t      word_q[$];
    logic [7:0] expected_bytes[$];
    logic [7:0] frame_model[FB_BYTES];
    int         errors = 0;
    int         words_sent = 0;
    logic       calm;

    // long stretch with no gaps on the command side
    assign calm = (words_sent >= 700) && (words_sent < 1000);

    page_framebuffer_glyph_blitter_top u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .operation        (cmd.op),
        .x_pos            (cmd.x),
        .y_pos            (cmd.y),
        .pixel_on         (cmd.on),
        .pattern_byte     (cmd.bits),
        .glyph_byte_index (cmd.gidx),
        .read_index       (cmd.raddr),
        .read_valid       (read_valid),
        .read_data        (read_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void plot(input int px, input int py, input logic on);
        int wx;
        int wy;
        int addr;
        wx = px % SCREEN_WIDTH;
        wy = py % SCREEN_HEIGHT;
        addr = (wy / 8) * SCREEN_WIDTH + wx;
        if (addr < FB_BYTES)
            frame_model[addr][wy % 8] = on;
    endfunction

    // advance the framebuffer model by one accepted word
    function automatic void apply_word(input word_t w);
        int col;
        int page;
        int row;
        case (w.op)
            OP_CLEAR:
            begin
                foreach (frame_model[i])
                    frame_model[i] = 8'h00;
            end
            OP_POINT:
                plot(int'(w.x), int'(w.y), w.on);
            OP_GLYPH:
            begin
                if (int'(w.gidx) < GLYPH_BYTES)
                begin
                    col = int'(w.gidx) % GLYPH_WIDTH;
                    page = int'(w.gidx) / GLYPH_WIDTH;
                    for (int k = 0; k < 8; k++)
                    begin
                        row = page * 8 + k;
                        if (row < GLYPH_HEIGHT)
                            plot(int'(w.x) + col, int'(w.y) + row, w.bits[k]);
                    end
                end
            end
            default:
                expected_bytes.push_back(int'(w.raddr) < FB_BYTES ?
                                         frame_model[w.raddr] : 8'h00);
        endcase
    endfunction

    function automatic word_t random_word(input op_t op);
        word_t w;
        w.op    = op;
        w.x     = 6'($urandom_range(0, 63));
        w.y     = 5'($urandom_range(0, 31));
        w.on    = 1'($urandom_range(0, 1));
        w.bits  = 8'($urandom_range(0, 255));
        w.gidx  = 6'($urandom_range(0, 63));
        w.raddr = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic word_t make_word(input op_t op, input int x, input int y,
                                        input int on, input int bits, input int gidx,
                                        input int raddr);
        word_t w;
        w.op    = op;
        w.x     = 6'(x);
        w.y     = 5'(y);
        w.on    = 1'(on);
        w.bits  = 8'(bits);
        w.gidx  = 6'(gidx);
        w.raddr = 8'(raddr);
        return w;
    endfunction

    // driver: a word stays on the ports until start && !busy takes it
    always @(posedge clk or negedge rst_n)
    begin
        logic give;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                apply_word(cmd);
            if (!(start && busy))
            begin
                give = (word_q.size() > 0) && (calm || $urandom_range(0, 99) >= 22);
                if (give)
                begin
                    cmd <= word_q.pop_front();
                    words_sent <= words_sent + 1;
                end
                start <= give;
            end
        end
    end

    // monitor: every strobe must match the oldest pending read
    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        if (rst_n && read_valid)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected read_data 0x%02h", read_data));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (read_data !== want)
                    report_mismatch($sformatf("read_data 0x%02h, want 0x%02h",
                                              read_data, want));
            end
        end
    end

    initial
    begin
        int    total;
        int    r;
        int    ox;
        int    oy;
        word_t w;

        foreach (frame_model[i])
            frame_model[i] = 8'h00;

        // directed: corners, wrap across pages and screen edges, ignored glyph indexes
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   0));
        word_q.push_back(make_word(OP_POINT, 0,  0, 1, 8'h00,  0,   0));
        word_q.push_back(make_word(OP_POINT, 63, 31, 1, 8'hFF, 63, 255));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   0));
        word_q.push_back(make_word(OP_READ,  63, 31, 1, 8'hFF, 63, 255));
        word_q.push_back(make_word(OP_POINT, 63, 31, 0, 8'h00,  0,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0, 255));
        word_q.push_back(make_word(OP_GLYPH, 63, 31, 1, 8'hFF, 35,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,  74));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0, 138));
        word_q.push_back(make_word(OP_GLYPH, 0,  0, 0, 8'hA5,  0,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   0));
        word_q.push_back(make_word(OP_GLYPH, 0,  0, 0, 8'hFF, 36,   0));
        word_q.push_back(make_word(OP_GLYPH, 0,  0, 0, 8'hFF, 63,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   1));
        word_q.push_back(make_word(OP_GLYPH, 5,  3, 0, 8'hFF, 13,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   6));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0, 134));
        word_q.push_back(make_word(OP_GLYPH, 5,  3, 0, 8'h00, 13,   0));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,  70));
        word_q.push_back(make_word(OP_CLEAR, 63, 31, 1, 8'hFF, 63, 255));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,  74));
        word_q.push_back(make_word(OP_READ,  0,  0, 0, 8'h00,  0,   0));

        // random: whole glyphs at a random origin, read back in their columns, mixed with single words
        total = word_q.size();
        while (total < N_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                ox = $urandom_range(0, 63);
                oy = $urandom_range(0, 31);
                for (int i = 0; i < GLYPH_BYTES; i++)
                begin
                    w = random_word(OP_GLYPH);
                    w.x = 6'(ox);
                    w.y = 5'(oy);
                    w.gidx = 6'(i);
                    word_q.push_back(w);
                end
                for (int i = 0; i < 10; i++)
                begin
                    w = random_word(OP_READ);
                    w.raddr = 8'($urandom_range(0, FB_PAGES - 1) * SCREEN_WIDTH +
                                 (ox + $urandom_range(0, GLYPH_WIDTH - 1)) % SCREEN_WIDTH);
                    word_q.push_back(w);
                end
                total += GLYPH_BYTES + 10;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    w = random_word(OP_CLEAR);
                else if (r < 32)
                    w = random_word(OP_POINT);
                else if (r < 62)
                    w = random_word(OP_GLYPH);
                else
                    w = random_word(OP_READ);
                word_q.push_back(w);
                total++;
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (word_q.size() > 0 || start);
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
